[rtl/stm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_pkg
// Shared types and constants of the software timer manager.
// ----------------------------------------------------------------------------
package stm_pkg;

    localparam int MAX_TIMERS_DEF = 64;
    localparam int INDEX_BITS_DEF = 16;
    localparam int COUNT_W        = 7;
    localparam int STACK_W        = 6;
    localparam int STATUS_W       = 3;
    localparam int ACTION_W       = 3;
    localparam int S_TDATA_W      = 200;
    localparam int M_TDATA_W      = 176;

    localparam logic [ACTION_W-1:0] ACT_TICK    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SET     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_KILL    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_QUERY   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_RESTART = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_RUN   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OWNER     = 3'd4;

    typedef struct packed {
        logic        running;
        logic        periodic;
        logic [31:0] expiry;
        logic [31:0] duration;
        logic [31:0] owner;
        logic [31:0] ttype;
        logic [63:0] value;
        logic [31:0] handle;
    } slot_rec_t;

endpackage

[rtl/software_timer_manager_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_timer_manager_top
// Timer pool held in a ring of slot cells scanned past one head stage.
// ----------------------------------------------------------------------------
// Kill, query, restart: one ring rotation, then the result from the response state;
// set adds a stack read before it. Bad index, no slot, unknown action: straight to the result.
// Tick: a counting rotation, then one result if no timer expired,
// or an emitting rotation that waits on output stalls, one result per expiry.
// Input accepted only when idle, i.e. one transaction per step; ring rotation sets the rate.
// Reset (and any timers_in_use write) clears all timers, tick and generation.
// ----------------------------------------------------------------------------
module software_timer_manager_top #(
    parameter int MAX_TIMERS = stm_pkg::MAX_TIMERS_DEF,
    parameter int INDEX_BITS = stm_pkg::INDEX_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [stm_pkg::COUNT_W-1:0]    cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // owner_id, duration_ticks, type_tag, user_value, periodic, handle
    input  logic [stm_pkg::S_TDATA_W-1:0]  s_tdata,
    // action
    input  logic [stm_pkg::ACTION_W-1:0]   s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status, timer_handle, expired_owner, expired_type, expired_value,
    // running_count
    output logic [stm_pkg::M_TDATA_W-1:0]  m_tdata,
    // is_expiry
    output logic                           m_tuser,
    output logic                           m_tlast
);

    localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CW = (INDEX_BITS > stm_pkg::COUNT_W) ? INDEX_BITS : stm_pkg::COUNT_W;
    localparam int CNT = stm_pkg::COUNT_W;
    localparam logic [31:0] IDX_MASK = 32'((64'd1 << INDEX_BITS) - 64'd1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TICK_A = 3'd1;
    localparam logic [2:0] S_TICK_B = 3'd2;
    localparam logic [2:0] S_SET_RD = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_RESP   = 3'd5;

    logic [2:0]     state_reg, state_next;
    logic [CNT-1:0] tiu_reg, tiu_next;
    logic [31:0]    tick_reg, tick_next;
    logic [31:0]    gen_reg, gen_next;
    logic [CNT-1:0] alloc_reg, alloc_next;
    logic [CNT-1:0] top_reg, top_next;
    logic [CNT-1:0] lw_reg, lw_next;
    logic [CNT-1:0] k_reg, k_next;
    logic [CNT-1:0] cnt_all_reg, cnt_all_next;
    logic [CNT-1:0] cnt_one_reg, cnt_one_next;
    logic [CNT-1:0] emit_reg, emit_next;
    logic [CNT-1:0] tgt_reg, tgt_next;
    logic           rdv_reg, rdv_next;
    logic [stm_pkg::STATUS_W-1:0] st_reg, st_next;
    logic [31:0]    rh_reg, rh_next;

    logic [stm_pkg::ACTION_W-1:0] op_reg;
    logic [31:0] owner_reg, dur_reg, type_reg, hdl_reg;
    logic [63:0] val_reg;
    logic        per_reg;

    logic        mv_reg, mv_next;
    logic [stm_pkg::M_TDATA_W-1:0] md_reg, md_next;
    logic        mu_reg, mu_next, ml_reg, ml_next;

    stm_pkg::slot_rec_t ring_q [MAX_TIMERS];
    stm_pkg::slot_rec_t head, head_new;
    logic        shift, init;
    logic        accept, can_emit, hit, k_end, at_tgt;
    logic [CW-1:0] idx_ext;
    logic          bad_idx;
    logic          push;
    logic [CNT-1:0] pop_idx;
    logic [stm_pkg::STACK_W-1:0] st_rdata, slot_pick;
    logic [stm_pkg::STATUS_W-1:0] chk_st;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign can_emit = !mv_reg || m_tready;
    assign head     = ring_q[0];
    assign hit      = head.running && (head.expiry == tick_reg);
    assign k_end    = (k_reg == CNT'(MAX_TIMERS - 1));
    assign at_tgt   = (k_reg == tgt_reg);
    assign init     = cfg_we;
    assign idx_ext  = CW'(s_tdata[161 +: INDEX_BITS]);
    assign bad_idx  = idx_ext >= CW'(tiu_reg);
    assign pop_idx  = top_reg - CNT'(1);
    assign slot_pick = rdv_reg ? st_rdata : top_reg[stm_pkg::STACK_W-1:0];

    always_comb
    begin
        if ((head.handle != hdl_reg) || !head.running)
        begin
            chk_st = stm_pkg::ST_NOT_RUN;
        end
        else if (head.owner != owner_reg)
        begin
            chk_st = stm_pkg::ST_OWNER;
        end
        else
        begin
            chk_st = stm_pkg::ST_OK;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TIMERS; gi++)
        begin : g_ring
            stm_pkg::slot_rec_t cd;
            if (gi == MAX_TIMERS - 1)
            begin : g_tail
                assign cd = head_new;
            end
            else
            begin : g_mid
                assign cd = ring_q[gi+1];
            end
            stm_cell #(.IDX(gi)) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .init  (init),
                .shift (shift),
                .d     (cd),
                .q     (ring_q[gi])
            );
        end
    endgenerate

    stm_ram #(.WIDTH(stm_pkg::STACK_W), .DEPTH(MAX_TIMERS), .AW(AW)) u_stack (
        .clk   (clk),
        .we    (push),
        .waddr (top_reg[AW-1:0]),
        .wdata (k_reg[stm_pkg::STACK_W-1:0]),
        .re    (accept),
        .raddr (pop_idx[AW-1:0]),
        .rdata (st_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        tiu_next     = tiu_reg;
        tick_next    = tick_reg;
        gen_next     = gen_reg;
        alloc_next   = alloc_reg;
        top_next     = top_reg;
        lw_next      = lw_reg;
        k_next       = k_reg;
        cnt_all_next = cnt_all_reg;
        cnt_one_next = cnt_one_reg;
        emit_next    = emit_reg;
        tgt_next     = tgt_reg;
        rdv_next     = rdv_reg;
        st_next      = st_reg;
        rh_next      = rh_reg;
        mv_next      = mv_reg && !m_tready;
        md_next      = md_reg;
        mu_next      = mu_reg;
        ml_next      = ml_reg;
        head_new     = head;
        shift        = 1'b0;
        push         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                k_next  = '0;
                st_next = stm_pkg::ST_OK;
                rh_next = '0;
                if (accept)
                begin
                    priority if (s_tuser == stm_pkg::ACT_TICK)
                    begin
                        tick_next    = tick_reg + 32'd1;
                        cnt_all_next = '0;
                        cnt_one_next = '0;
                        state_next   = S_TICK_A;
                    end
                    else if (s_tuser == stm_pkg::ACT_SET)
                    begin
                        if (top_reg == '0)
                        begin
                            st_next    = stm_pkg::ST_NO_SLOT;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            top_next   = pop_idx;
                            rdv_next   = pop_idx >= lw_reg;
                            lw_next    = (pop_idx < lw_reg) ? pop_idx : lw_reg;
                            state_next = S_SET_RD;
                        end
                    end
                    else if (s_tuser == stm_pkg::ACT_KILL || s_tuser == stm_pkg::ACT_QUERY
                             || s_tuser == stm_pkg::ACT_RESTART)
                    begin
                        if (bad_idx)
                        begin
                            st_next    = stm_pkg::ST_BAD_INDEX;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            tgt_next   = idx_ext[CNT-1:0];
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        st_next    = stm_pkg::ST_BAD_INDEX;
                        state_next = S_RESP;
                    end
                end
            end
            S_SET_RD:
            begin
                tgt_next   = (CNT'(slot_pick) >= CNT'(MAX_TIMERS)) ? '0 : CNT'(slot_pick);
                gen_next   = gen_reg + 32'd1;
                alloc_next = alloc_reg + CNT'(1);
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                shift = 1'b1;
                if (at_tgt)
                begin
                    if (op_reg == stm_pkg::ACT_SET)
                    begin
                        head_new.running  = 1'b1;
                        head_new.periodic = per_reg;
                        head_new.expiry   = tick_reg + dur_reg;
                        head_new.duration = dur_reg;
                        head_new.owner    = owner_reg;
                        head_new.ttype    = type_reg;
                        head_new.value    = val_reg;
                        head_new.handle   = (head.handle & IDX_MASK) | (gen_reg << INDEX_BITS);
                        rh_next           = head_new.handle;
                    end
                    else
                    begin
                        st_next = chk_st;
                        if (chk_st == stm_pkg::ST_OK && op_reg == stm_pkg::ACT_KILL)
                        begin
                            head_new.running = 1'b0;
                            push             = top_reg < CNT'(MAX_TIMERS);
                            top_next         = push ? top_reg + CNT'(1) : top_reg;
                            alloc_next       = (alloc_reg != '0) ? alloc_reg - CNT'(1) : alloc_reg;
                        end
                        else if (chk_st == stm_pkg::ST_OK && op_reg == stm_pkg::ACT_RESTART)
                        begin
                            head_new.expiry = tick_reg + head.duration;
                        end
                    end
                end
                k_next = k_reg + CNT'(1);
                if (k_end)
                begin
                    state_next = S_RESP;
                end
            end
            S_TICK_A:
            begin
                shift = 1'b1;
                if (hit)
                begin
                    cnt_all_next = cnt_all_reg + CNT'(1);
                    if (!head.periodic)
                    begin
                        cnt_one_next = cnt_one_reg + CNT'(1);
                    end
                end
                k_next = k_reg + CNT'(1);
                if (k_end)
                begin
                    k_next     = '0;
                    emit_next  = '0;
                    alloc_next = alloc_reg - cnt_one_next;
                    state_next = (cnt_all_next == '0) ? S_RESP : S_TICK_B;
                end
            end
            S_TICK_B:
            begin
                if (!hit || can_emit)
                begin
                    shift = 1'b1;
                    if (hit)
                    begin
                        mv_next   = 1'b1;
                        mu_next   = 1'b1;
                        ml_next   = (emit_reg == cnt_all_reg - CNT'(1));
                        md_next   = {6'd0, alloc_reg, head.value, head.ttype, head.owner,
                                     head.handle, stm_pkg::ST_OK};
                        emit_next = emit_reg + CNT'(1);
                        if (head.periodic)
                        begin
                            head_new.expiry = tick_reg + head.duration;
                        end
                        else
                        begin
                            head_new.running = 1'b0;
                            push             = top_reg < CNT'(MAX_TIMERS);
                            top_next         = push ? top_reg + CNT'(1) : top_reg;
                        end
                    end
                    k_next = k_reg + CNT'(1);
                    if (k_end)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RESP:
            begin
                if (can_emit)
                begin
                    mv_next    = 1'b1;
                    mu_next    = 1'b0;
                    ml_next    = 1'b1;
                    md_next    = {6'd0, alloc_reg, 64'd0, 32'd0, 32'd0, rh_reg, st_reg};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            tiu_next   = (cfg_wdata > CNT'(MAX_TIMERS)) ? CNT'(MAX_TIMERS) : cfg_wdata;
            tick_next  = '0;
            gen_next   = '0;
            alloc_next = '0;
            top_next   = tiu_next;
            lw_next    = tiu_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tiu_reg   <= CNT'(MAX_TIMERS);
            tick_reg  <= '0;
            gen_reg   <= '0;
            alloc_reg <= '0;
            top_reg   <= CNT'(MAX_TIMERS);
            lw_reg    <= CNT'(MAX_TIMERS);
            k_reg     <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tiu_reg   <= tiu_next;
            tick_reg  <= tick_next;
            gen_reg   <= gen_next;
            alloc_reg <= alloc_next;
            top_reg   <= top_next;
            lw_reg    <= lw_next;
            k_reg     <= k_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_all_reg <= cnt_all_next;
        cnt_one_reg <= cnt_one_next;
        emit_reg    <= emit_next;
        tgt_reg     <= tgt_next;
        rdv_reg     <= rdv_next;
        st_reg      <= st_next;
        rh_reg      <= rh_next;
        md_reg      <= md_next;
        mu_reg      <= mu_next;
        ml_reg      <= ml_next;
        if (accept)
        begin
            op_reg    <= s_tuser;
            owner_reg <= s_tdata[31:0];
            dur_reg   <= s_tdata[63:32];
            type_reg  <= s_tdata[95:64];
            val_reg   <= s_tdata[159:96];
            per_reg   <= s_tdata[160];
            hdl_reg   <= s_tdata[192:161];
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;
    assign m_tlast  = ml_reg;

endmodule

[rtl/stm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module stm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/stm_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_cell
// One timer slot record in the circulating ring of slots.
// ----------------------------------------------------------------------------
module stm_cell #(
    parameter int IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              init,
    input  logic              shift,
    input  stm_pkg::slot_rec_t d,
    output stm_pkg::slot_rec_t q
);

    logic               running_reg;
    logic [31:0]        handle_reg;
    stm_pkg::slot_rec_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            handle_reg  <= 32'(IDX);
        end
        else if (init)
        begin
            running_reg <= 1'b0;
            handle_reg  <= 32'(IDX);
        end
        else if (shift)
        begin
            running_reg <= d.running;
            handle_reg  <= d.handle;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift && !init)
        begin
            data_reg <= d;
        end
    end

    always_comb
    begin
        q         = data_reg;
        q.running = running_reg;
        q.handle  = handle_reg;
    end

endmodule

[rtl/stm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_checker
// Port-level checks on the result stream of the timer manager.
// ----------------------------------------------------------------------------
module stm_checker #(
    parameter int MAX_TIMERS = stm_pkg::MAX_TIMERS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [stm_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser,
    input logic                          m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    a_exp_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[2:0] == stm_pkg::ST_OK)
        else $error("expiry with non-zero status");

    a_noexp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[162:35] == '0 && m_tlast)
        else $error("command result carries timer data or is not last");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[169:163] <= 7'(MAX_TIMERS))
        else $error("running count above pool size");

endmodule

bind software_timer_manager_top stm_checker #(.MAX_TIMERS(MAX_TIMERS)) u_stm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
